[hdl/scp_pkg.sv]
// Shared types and constants of the scan curb point selector.
`default_nettype none
package scp_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned TAG_BITS   = 16;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_BITS  = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [TAG_BITS-1:0]          tag_t;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } side_mode_e;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    tag_t   point_tag;
    logic   scan_end;
  } in_beat_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    tag_t   out_tag;
    logic   rear_half;
    logic   last_of_scan;
  } out_beat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    tag_t   tag;
  } point_t;

  typedef struct packed {
    point_t pt;
    mag_t   mag;
    logic   pref;
    logic   rear;
    logic   scan_end;
  } pt_info_t;

  typedef struct packed {
    point_t front_pt;
    point_t rear_pt;
    logic   has_front;
    logic   has_rear;
  } scan_res_t;

endpackage
`default_nettype wire

[hdl/scp_stage.sv]
// Input register: classifies one point by half, side and |y|.
`default_nettype none
module scp_stage (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire scp_pkg::in_beat_t      beat_i,
  input  wire scp_pkg::side_mode_e    side_mode_i,
  output scp_pkg::pt_info_t           info_o,
  output logic                        valid_o
);

  scp_pkg::pt_info_t info_d, info_q;
  logic              valid_q;
  logic              y_neg, y_zero;

  always_comb begin
    y_neg  = beat_i.pos_y[scp_pkg::COORD_BITS-1];
    y_zero = (beat_i.pos_y == '0);
    info_d.pt.x     = beat_i.pos_x;
    info_d.pt.y     = beat_i.pos_y;
    info_d.pt.z     = beat_i.pos_z;
    info_d.pt.tag   = beat_i.point_tag;
    info_d.mag      = y_neg ? scp_pkg::mag_t'(~beat_i.pos_y + 1'b1)
                            : scp_pkg::mag_t'(beat_i.pos_y);
    info_d.pref     = (side_mode_i == scp_pkg::SIDE_RIGHT) ? (!y_neg && !y_zero) : y_neg;
    info_d.rear     = beat_i.pos_x[scp_pkg::COORD_BITS-1];
    info_d.scan_end = beat_i.scan_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      info_q <= info_d;
    end
  end

  assign info_o  = info_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

[hdl/scp_half.sv]
// Running best candidates of one half of a scan.
`default_nettype none
module scp_half (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire scp_pkg::pt_info_t  info_i,
  input  wire logic               upd_i,
  input  wire logic               clr_i,
  output logic                    seen_o,
  output scp_pkg::point_t         sel_o
);

  logic            seen_d, seen_q;
  logic            pref_seen_d, pref_seen_q;
  scp_pkg::point_t pref_pt_d, pref_pt_q;
  scp_pkg::point_t near_pt_d, near_pt_q;
  scp_pkg::mag_t   pref_mag_d, pref_mag_q;
  scp_pkg::mag_t   near_mag_d, near_mag_q;
  logic            take_near, take_pref;

  always_comb begin
    take_near   = upd_i && (!seen_q || (info_i.mag < near_mag_q));
    take_pref   = upd_i && info_i.pref && (!pref_seen_q || (info_i.mag > pref_mag_q));
    seen_d      = seen_q || upd_i;
    pref_seen_d = pref_seen_q || (upd_i && info_i.pref);
    near_pt_d   = take_near ? info_i.pt  : near_pt_q;
    near_mag_d  = take_near ? info_i.mag : near_mag_q;
    pref_pt_d   = take_pref ? info_i.pt  : pref_pt_q;
    pref_mag_d  = take_pref ? info_i.mag : pref_mag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      pref_seen_q <= 1'b0;
    end else if (clr_i) begin
      seen_q      <= 1'b0;
      pref_seen_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      pref_seen_q <= pref_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    near_pt_q  <= near_pt_d;
    near_mag_q <= near_mag_d;
    pref_pt_q  <= pref_pt_d;
    pref_mag_q <= pref_mag_d;
  end

  assign seen_o = seen_d;
  assign sel_o  = pref_seen_d ? pref_pt_d : near_pt_d;

endmodule
`default_nettype wire

[hdl/scp_obuf.sv]
// Result queue: one entry per finished scan, drained one beat at a time.
`default_nettype none
module scp_obuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire scp_pkg::scan_res_t  res_i,
  output logic                     full_o,
  output logic                     near_full_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output scp_pkg::out_beat_t       out_data_o
);

  scp_pkg::scan_res_t                  mem_q [scp_pkg::QDEPTH];
  logic [scp_pkg::QPTR_BITS-1:0]       wr_ptr_q, rd_ptr_q;
  logic [scp_pkg::QCNT_BITS-1:0]       cnt_q, cnt_d;
  logic                                half_q, half_d;
  scp_pkg::scan_res_t                  head;
  logic                                emit_rear, is_last, beat_done, pop;

  always_comb begin
    head        = mem_q[rd_ptr_q];
    out_valid_o = (cnt_q != '0);
    emit_rear   = half_q || !head.has_front;
    is_last     = emit_rear || !head.has_rear;
    out_data_o.out_x        = emit_rear ? head.rear_pt.x   : head.front_pt.x;
    out_data_o.out_y        = emit_rear ? head.rear_pt.y   : head.front_pt.y;
    out_data_o.out_z        = emit_rear ? head.rear_pt.z   : head.front_pt.z;
    out_data_o.out_tag      = emit_rear ? head.rear_pt.tag : head.front_pt.tag;
    out_data_o.rear_half    = emit_rear;
    out_data_o.last_of_scan = is_last;
    beat_done = out_valid_o && !out_stall_i;
    pop       = beat_done && is_last;
    half_d    = beat_done ? !is_last : half_q;
    cnt_d     = cnt_q + scp_pkg::QCNT_BITS'(push_i) - scp_pkg::QCNT_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      half_q   <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q  <= cnt_d;
      half_q <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  assign full_o      = (cnt_q == scp_pkg::QCNT_BITS'(scp_pkg::QDEPTH));
  assign near_full_o = (cnt_q >= scp_pkg::QCNT_BITS'(scp_pkg::QDEPTH - 1));

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != scp_pkg::QCNT_BITS'(scp_pkg::QDEPTH)) || pop)
    else $error("result queue overflow");

  a_push_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (res_i.has_front || res_i.has_rear))
    else $error("scan end without a result");

  a_half_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> (out_valid_o && head.has_front && head.has_rear))
    else $error("rear beat pending on an entry without two halves");

endmodule
`default_nettype wire

[hdl/scan_curb_point_select_unit.sv]
// Top level of the scan curb point selector.
// One point is taken per clock cycle while in_stall_o is low. A point goes through the input
// register and then updates the running front and rear candidates; the point that ends a scan
// places that scan's one or two results in a four-scan result queue as it leaves that register.
// Results leave one beat per cycle while out_stall_i is low, front half first; in_stall_o rises
// only while that queue is nearly full. The configuration channel, always ready, sets side_mode.
`default_nettype none
module scan_curb_point_select_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire scp_pkg::in_beat_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output scp_pkg::out_beat_t       out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i
);

  scp_pkg::side_mode_e side_mode_q;
  scp_pkg::pt_info_t   info;
  scp_pkg::scan_res_t  res;
  scp_pkg::point_t     front_sel, rear_sel;
  logic                st_valid, load, scan_done;
  logic                front_seen, rear_seen;
  logic                q_full, q_near_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_mode_q <= scp_pkg::SIDE_LEFT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      side_mode_q <= scp_pkg::side_mode_e'(cfg_data_i);
    end
  end

  assign in_stall_o = q_full || (q_near_full && st_valid && info.scan_end);
  assign load       = in_valid_i && !in_stall_o;
  assign scan_done  = st_valid && info.scan_end;

  scp_stage u_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .beat_i      (in_data_i),
    .side_mode_i (side_mode_q),
    .info_o      (info),
    .valid_o     (st_valid)
  );

  scp_half u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .info_i (info),
    .upd_i  (st_valid && !info.rear),
    .clr_i  (scan_done),
    .seen_o (front_seen),
    .sel_o  (front_sel)
  );

  scp_half u_rear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .info_i (info),
    .upd_i  (st_valid && info.rear),
    .clr_i  (scan_done),
    .seen_o (rear_seen),
    .sel_o  (rear_sel)
  );

  always_comb begin
    res.front_pt  = front_sel;
    res.rear_pt   = rear_sel;
    res.has_front = front_seen;
    res.has_rear  = rear_seen;
  end

  scp_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (scan_done),
    .res_i       (res),
    .full_o      (q_full),
    .near_full_o (q_near_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench of the scan curb point selector.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    scp_pkg::point_t              pt;
    logic [scp_pkg::COORD_BITS:0] mag;
  } curb_cand_t;

  typedef struct {
    bit         seen;
    bit         pref_seen;
    curb_cand_t pref_c;
    curb_cand_t near_c;
  } half_track_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  scp_pkg::in_beat_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  scp_pkg::out_beat_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i  = 1'b0;

  half_track_t         half_q [2];
  scp_pkg::side_mode_e side_q = scp_pkg::SIDE_LEFT;
  scp_pkg::out_beat_t  curb_expect_q [$];

  bit calm       = 1'b0;
  bit hold_req   = 1'b0;
  int errors     = 0;
  int points_sent;
  int scans_done;
  int results_checked;
  int mode_writes;

  scan_curb_point_select_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d curb results outstanding", curb_expect_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin : drive_out_stall
    int hold_left;
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 22);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin : check_results
    scp_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (curb_expect_q.size() == 0) begin
        $error("unexpected result beat %0h", out_data_o);
        errors++;
      end else begin
        want = curb_expect_q.pop_front();
        check_field("out_x", want.out_x, out_data_o.out_x);
        check_field("out_y", want.out_y, out_data_o.out_y);
        check_field("out_z", want.out_z, out_data_o.out_z);
        check_field("out_tag", want.out_tag, out_data_o.out_tag);
        check_field("rear_half", want.rear_half, out_data_o.rear_half);
        check_field("last_of_scan", want.last_of_scan, out_data_o.last_of_scan);
        results_checked++;
      end
    end
  end

  task automatic track_curb_point(scp_pkg::in_beat_t b);
    curb_cand_t                          c;
    logic signed [scp_pkg::COORD_BITS:0] ys;
    bit                                  pref;
    int                                  h;
    scp_pkg::out_beat_t                  res [2];
    int                                  n;
    c.pt.x   = b.pos_x;
    c.pt.y   = b.pos_y;
    c.pt.z   = b.pos_z;
    c.pt.tag = b.point_tag;
    ys       = {b.pos_y[scp_pkg::COORD_BITS-1], b.pos_y};
    c.mag    = ys[scp_pkg::COORD_BITS] ? -ys : ys;
    pref     = (side_q == scp_pkg::SIDE_RIGHT) ? (ys > 0) : (ys < 0);
    h        = b.pos_x[scp_pkg::COORD_BITS-1];
    if (!half_q[h].seen || c.mag < half_q[h].near_c.mag) half_q[h].near_c = c;
    half_q[h].seen = 1'b1;
    if (pref) begin
      if (!half_q[h].pref_seen || c.mag > half_q[h].pref_c.mag) half_q[h].pref_c = c;
      half_q[h].pref_seen = 1'b1;
    end
    points_sent++;
    if (!b.scan_end) return;
    n = 0;
    for (int k = 0; k < 2; k++) begin
      if (half_q[k].seen) begin
        c = half_q[k].pref_seen ? half_q[k].pref_c : half_q[k].near_c;
        res[n] = '{out_x: c.pt.x, out_y: c.pt.y, out_z: c.pt.z, out_tag: c.pt.tag,
                   rear_half: k[0], last_of_scan: 1'b0};
        n++;
      end
    end
    res[n-1].last_of_scan = 1'b1;
    for (int k = 0; k < n; k++) curb_expect_q = {curb_expect_q, res[k]};
    half_q[0] = '{default: '0};
    half_q[1] = '{default: '0};
    scans_done++;
  endtask

  task automatic send_point(scp_pkg::in_beat_t b);
    int gap;
    bit acc;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 22) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
    end while (!acc);
    track_curb_point(b);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (curb_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_side_mode(scp_pkg::side_mode_e m);
    bit acc;
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i <= 1'b0;
    side_q = m;
    mode_writes++;
  endtask

  function automatic scp_pkg::in_beat_t mk_point(int x, int y, int z, int tag, bit ends);
    scp_pkg::in_beat_t b;
    b.pos_x     = x[scp_pkg::COORD_BITS-1:0];
    b.pos_y     = y[scp_pkg::COORD_BITS-1:0];
    b.pos_z     = z[scp_pkg::COORD_BITS-1:0];
    b.point_tag = tag[scp_pkg::TAG_BITS-1:0];
    b.scan_end  = ends;
    return b;
  endfunction

  function automatic scp_pkg::in_beat_t random_point(bit ends);
    int x;
    int y;
    case ($urandom_range(0, 3))
      0: x = 0;
      1: x = -1;
      default: x = $urandom;
    endcase
    if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 1) ? 32767 : -32768;
    case ($urandom_range(0, 4))
      0: y = $urandom;
      1: y = $urandom_range(0, 6) - 3;
      2: y = $urandom_range(0, 200) - 100;
      3: begin
        case ($urandom_range(0, 3))
          0: y = -32768;
          1: y = 32767;
          2: y = -32767;
          default: y = 0;
        endcase
      end
      default: y = $urandom_range(0, 4000) - 2000;
    endcase
    return mk_point(x, y, $urandom, $urandom, ends);
  endfunction

  task automatic send_random_scan(int len);
    for (int i = 0; i < len; i++) send_point(random_point(i == len - 1));
  endtask

  task automatic test_left_mode_cases();
    write_side_mode(scp_pkg::SIDE_LEFT);
    send_point(mk_point(10, 0, 1, 16'h0001, 1'b1));
    send_point(mk_point(-1, -32768, -5, 16'h0002, 1'b1));
    send_point(mk_point(0, -5, 0, 16'h0010, 1'b0));
    send_point(mk_point(3, -9, 0, 16'h0011, 1'b0));
    send_point(mk_point(4, -9, 0, 16'h0012, 1'b0));
    send_point(mk_point(5, 3, 0, 16'h0013, 1'b0));
    send_point(mk_point(-7, 7, 0, 16'h0020, 1'b0));
    send_point(mk_point(-8, 2, 0, 16'h0021, 1'b0));
    send_point(mk_point(-9, 2, 0, 16'h0022, 1'b1));
    send_point(mk_point(32767, 32767, -32768, 16'hFFFF, 1'b0));
    send_point(mk_point(-32768, -32768, 32767, 16'h0000, 1'b0));
    send_point(mk_point(0, -32767, 0, 16'h5555, 1'b0));
    send_point(mk_point(0, -32768, 0, 16'hAAAA, 1'b0));
    send_point(mk_point(0, -1, 0, 16'h1234, 1'b1));
  endtask

  task automatic test_right_mode_and_switch();
    write_side_mode(scp_pkg::SIDE_RIGHT);
    send_point(mk_point(1, 5, 0, 16'h0030, 1'b0));
    send_point(mk_point(2, 32767, 0, 16'h0031, 1'b0));
    send_point(mk_point(3, -32768, 0, 16'h0032, 1'b0));
    send_point(mk_point(4, 32767, 0, 16'h0033, 1'b0));
    send_point(mk_point(-32768, 0, 0, 16'h0034, 1'b1));
    send_point(mk_point(6, -4, 0, 16'h0040, 1'b0));
    send_point(mk_point(7, 6, 0, 16'h0041, 1'b0));
    write_side_mode(scp_pkg::SIDE_LEFT);
    send_point(mk_point(8, -100, 0, 16'h0042, 1'b0));
    send_point(mk_point(-3, 50, 0, 16'h0043, 1'b1));
  endtask

  task automatic test_random_scans();
    int sent;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      write_side_mode(ph[0] ? scp_pkg::SIDE_LEFT : scp_pkg::SIDE_RIGHT);
      sent = 0;
      while (sent < 110) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
        send_random_scan(len);
        sent += len;
      end
      if ($urandom_range(0, 1)) begin
        send_point(random_point(1'b0));
        send_point(random_point(1'b0));
      end
    end
    send_point(random_point(1'b1));
  endtask

  task automatic test_full_queue();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_random_scan($urandom_range(1, 2));
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 4; i++) begin
      send_random_scan($urandom_range(1, 5));
      wait_idle();
    end
  endtask

  task automatic test_no_idle_stretch();
    int sent;
    int len;
    calm = 1'b1;
    sent = 0;
    while (sent < 80) begin
      len = $urandom_range(1, 4);
      send_random_scan(len);
      sent += len;
    end
    calm = 1'b0;
  endtask

  initial begin
    half_q[0] = '{default: '0};
    half_q[1] = '{default: '0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_left_mode_cases();
    test_right_mode_and_switch();
    test_random_scans();
    test_full_queue();
    test_sender_pause();
    test_no_idle_stretch();
    write_side_mode(scp_pkg::SIDE_RIGHT);
    test_full_queue();
    wait_idle();
    $display("Sent %0d points in %0d scans under %0d side mode writes;", points_sent,
             scans_done, mode_writes);
    $display("checked %0d curb beats with random gaps, long output hold-off and pauses.",
             results_checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/scp_pkg.sv
hdl/scp_stage.sv
hdl/scp_half.sv
hdl/scp_obuf.sv
hdl/scan_curb_point_select_unit.sv
dv/testbench.sv
